[design/tsqe_pkg.sv]
// Shared types, widths and helpers for the thick segment quad expander.
`default_nettype none

package tsqe_pkg;

  localparam int COORD_W      = 24;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int SUM_W        = COORD_W + 1;
  localparam int LW_W         = 16;
  localparam int MAG_W        = 24;
  localparam int SQ_W         = 2 * MAG_W;
  localparam int RAD_W        = 64;
  localparam int RAD_SHIFT    = 14;
  localparam int ROOT_W       = RAD_W / 2;
  localparam int SQRT_REM_W   = ROOT_W + 2;
  localparam int DIV_PRESHIFT = 6;
  localparam int OFS_W        = LW_W + 1;

  localparam logic [LW_W-1:0] LINE_WIDTH_RESET = 16'd256;
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_VERT,
    KIND_HORZ,
    KIND_DIAG
  } seg_kind_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    seg_kind_t                 kind;
    logic                      same_sign;
  } seg_t;

  typedef struct packed {
    seg_t             seg;
    logic [MAG_W-1:0] adx;
    logic [MAG_W-1:0] ady;
  } sqrt_side_t;

  typedef struct packed {
    logic [RAD_W-1:0]      rad;
    logic [SQRT_REM_W-1:0] rem;
    logic [ROOT_W-1:0]     root;
  } sqrt_work_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] c0x;
    logic signed [COORD_W-1:0] c0y;
    logic signed [COORD_W-1:0] c1x;
    logic signed [COORD_W-1:0] c1y;
    logic signed [COORD_W-1:0] c2x;
    logic signed [COORD_W-1:0] c2y;
    logic signed [COORD_W-1:0] c3x;
    logic signed [COORD_W-1:0] c3y;
  } quad_t;

  function automatic logic signed [COORD_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SUM_W'(COORD_MAX)) begin
      r = COORD_MAX;
    end else if (v < SUM_W'(COORD_MIN)) begin
      r = COORD_MIN;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/tsqe_if.sv]
// Handshake channel interfaces for segment input and quad output.
`default_nettype none

interface tsqe_seg_if;
  logic                                valid;
  logic                                ready;
  logic signed [tsqe_pkg::COORD_W-1:0] start_x;
  logic signed [tsqe_pkg::COORD_W-1:0] start_y;
  logic signed [tsqe_pkg::COORD_W-1:0] end_x;
  logic signed [tsqe_pkg::COORD_W-1:0] end_y;

  modport source(output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink(input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface tsqe_quad_if;
  logic                                valid;
  logic                                ready;
  logic signed [tsqe_pkg::COORD_W-1:0] corner0_x;
  logic signed [tsqe_pkg::COORD_W-1:0] corner0_y;
  logic signed [tsqe_pkg::COORD_W-1:0] corner1_x;
  logic signed [tsqe_pkg::COORD_W-1:0] corner1_y;
  logic signed [tsqe_pkg::COORD_W-1:0] corner2_x;
  logic signed [tsqe_pkg::COORD_W-1:0] corner2_y;
  logic signed [tsqe_pkg::COORD_W-1:0] corner3_x;
  logic signed [tsqe_pkg::COORD_W-1:0] corner3_y;

  modport source(output valid, corner0_x, corner0_y, corner1_x, corner1_y,
                 corner2_x, corner2_y, corner3_x, corner3_y, input ready);
  modport sink(input valid, corner0_x, corner0_y, corner1_x, corner1_y,
               corner2_x, corner2_y, corner3_x, corner3_y, output ready);
endinterface

`default_nettype wire

[design/tsqe_sqrt_cell.sv]
// One digit cell of the pipelined integer square root, two radicand bits per cell.
`default_nettype none

module tsqe_sqrt_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   valid_in,
  input  tsqe_pkg::sqrt_side_t   side_in,
  input  tsqe_pkg::sqrt_work_t   work_in,
  output logic                   valid_out,
  output tsqe_pkg::sqrt_side_t   side_out,
  output tsqe_pkg::sqrt_work_t   work_out
);

  logic [tsqe_pkg::SQRT_REM_W+1:0] cur;
  logic [tsqe_pkg::SQRT_REM_W+1:0] trial;
  tsqe_pkg::sqrt_work_t            work_next;

  always_comb begin
    cur = {work_in.rem, work_in.rad[tsqe_pkg::RAD_W-1 -: 2]};
    trial = (tsqe_pkg::SQRT_REM_W+2)'({work_in.root, 2'b01});
    work_next.rad = {work_in.rad[tsqe_pkg::RAD_W-3:0], 2'b00};
    if (cur >= trial) begin
      work_next.rem  = tsqe_pkg::SQRT_REM_W'(cur - trial);
      work_next.root = {work_in.root[tsqe_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      work_next.rem  = tsqe_pkg::SQRT_REM_W'(cur);
      work_next.root = {work_in.root[tsqe_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      work_out <= work_next;
    end
  end

endmodule

`default_nettype wire

[design/tsqe_div_cell.sv]
// One quotient-bit cell of the two restoring dividers that form the unit normal.
`default_nettype none

module tsqe_div_cell #(
  parameter int QW = 17
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             valid_in,
  input  tsqe_pkg::seg_t                   seg_in,
  input  logic [tsqe_pkg::ROOT_W-1:0]      len_in,
  input  logic [tsqe_pkg::ROOT_W-1:0]      rem_c_in,
  input  logic [tsqe_pkg::ROOT_W-1:0]      rem_s_in,
  input  logic [QW-1:0]                    q_c_in,
  input  logic [QW-1:0]                    q_s_in,
  output logic                             valid_out,
  output tsqe_pkg::seg_t                   seg_out,
  output logic [tsqe_pkg::ROOT_W-1:0]      len_out,
  output logic [tsqe_pkg::ROOT_W-1:0]      rem_c_out,
  output logic [tsqe_pkg::ROOT_W-1:0]      rem_s_out,
  output logic [QW-1:0]                    q_c_out,
  output logic [QW-1:0]                    q_s_out
);

  logic [tsqe_pkg::ROOT_W:0]   t_c;
  logic [tsqe_pkg::ROOT_W:0]   t_s;
  logic [tsqe_pkg::ROOT_W:0]   len_ext;
  logic                        bit_c;
  logic                        bit_s;
  logic [tsqe_pkg::ROOT_W-1:0] rem_c_next;
  logic [tsqe_pkg::ROOT_W-1:0] rem_s_next;

  always_comb begin
    t_c     = {rem_c_in, 1'b0};
    t_s     = {rem_s_in, 1'b0};
    len_ext = {1'b0, len_in};
    bit_c   = (t_c >= len_ext);
    bit_s   = (t_s >= len_ext);
    rem_c_next = bit_c ? tsqe_pkg::ROOT_W'(t_c - len_ext) : tsqe_pkg::ROOT_W'(t_c);
    rem_s_next = bit_s ? tsqe_pkg::ROOT_W'(t_s - len_ext) : tsqe_pkg::ROOT_W'(t_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg_out   <= seg_in;
      len_out   <= len_in;
      rem_c_out <= rem_c_next;
      rem_s_out <= rem_s_next;
      q_c_out   <= {q_c_in[QW-2:0], bit_c};
      q_s_out   <= {q_s_in[QW-2:0], bit_s};
    end
  end

endmodule

`default_nettype wire

[design/tsqe_skid.sv]
// Output register with a spare entry; the pipeline stalls only once the spare entry is full.
`default_nettype none

module tsqe_skid (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  input  tsqe_pkg::quad_t     push_data,
  output logic                room,
  tsqe_quad_if.source         quad
);

  logic            main_valid;
  logic            spare_valid;
  tsqe_pkg::quad_t main;
  tsqe_pkg::quad_t spare;
  logic            push;
  logic            pop;

  assign room = !spare_valid;
  assign push = push_valid && !spare_valid;
  assign pop  = main_valid && quad.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else if (pop || !main_valid) begin
      main_valid  <= spare_valid || push;
      spare_valid <= 1'b0;
    end else if (push) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !main_valid) begin
      main <= spare_valid ? spare : push_data;
    end else if (push) begin
      spare <= push_data;
    end
  end

  assign quad.valid     = main_valid;
  assign quad.corner0_x = main.c0x;
  assign quad.corner0_y = main.c0y;
  assign quad.corner1_x = main.c1x;
  assign quad.corner1_y = main.c1y;
  assign quad.corner2_x = main.c2x;
  assign quad.corner2_y = main.c2y;
  assign quad.corner3_x = main.c3x;
  assign quad.corner3_y = main.c3y;

endmodule

`default_nettype wire

[design/thick_segment_quad_expand.sv]
// Thick segment quad expander: orders a segment and returns the four corners of its quad.
// Registered stages in order: input, squares, radicand, the 32 square-root cells,
// the NORMAL_ITERATIONS + 1 divider cells, width scaling and the output register.
// Throughput: one segment per cycle; a full spare output entry stalls the whole chain.
// Reset: line_width returns to 256 and all stage valids clear; no clearing pass.
`default_nettype none

module thick_segment_quad_expand #(
  parameter int NORMAL_ITERATIONS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [tsqe_pkg::LW_W-1:0] cfg_data,
  tsqe_seg_if.sink                  segment,
  tsqe_quad_if.source               quad
);

  localparam int QW = NORMAL_ITERATIONS + 1;
  localparam int PW = tsqe_pkg::LW_W + QW;
  localparam int ROOT_W = tsqe_pkg::ROOT_W;
  localparam logic [QW-1:0] UNIT_ONE = QW'(1) << NORMAL_ITERATIONS;
  localparam logic [PW-1:0] ROUND_HALF = PW'(1) << NORMAL_ITERATIONS;

  logic [tsqe_pkg::LW_W-1:0] line_width;
  logic                      en;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= tsqe_pkg::LINE_WIDTH_RESET;
    end else if (cfg_we) begin
      line_width <= cfg_data;
    end
  end

  // input stage: order endpoints and classify
  logic signed [tsqe_pkg::DIFF_W-1:0] dx;
  logic signed [tsqe_pkg::DIFF_W-1:0] dy;
  logic signed [tsqe_pkg::DIFF_W-1:0] adx_full;
  logic signed [tsqe_pkg::DIFF_W-1:0] ady_full;
  logic                               dx_zero;
  logic                               dy_zero;
  logic                               swap;
  tsqe_pkg::sqrt_side_t               a_side_next;
  logic                               a_valid;
  tsqe_pkg::sqrt_side_t               a_side;

  assign segment.ready = en;

  always_comb begin
    dx = tsqe_pkg::DIFF_W'(segment.end_x) - tsqe_pkg::DIFF_W'(segment.start_x);
    dy = tsqe_pkg::DIFF_W'(segment.end_y) - tsqe_pkg::DIFF_W'(segment.start_y);
    adx_full = dx[tsqe_pkg::DIFF_W-1] ? -dx : dx;
    ady_full = dy[tsqe_pkg::DIFF_W-1] ? -dy : dy;
    dx_zero = (segment.start_x == segment.end_x);
    dy_zero = (segment.start_y == segment.end_y);
    swap = dx_zero ? !(segment.start_y < segment.end_y) : !(segment.start_x < segment.end_x);
    if (swap) begin
      a_side_next.seg.sx = segment.end_x;
      a_side_next.seg.sy = segment.end_y;
      a_side_next.seg.ex = segment.start_x;
      a_side_next.seg.ey = segment.start_y;
    end else begin
      a_side_next.seg.sx = segment.start_x;
      a_side_next.seg.sy = segment.start_y;
      a_side_next.seg.ex = segment.end_x;
      a_side_next.seg.ey = segment.end_y;
    end
    if (dx_zero) begin
      a_side_next.seg.kind = tsqe_pkg::KIND_VERT;
    end else if (dy_zero) begin
      a_side_next.seg.kind = tsqe_pkg::KIND_HORZ;
    end else begin
      a_side_next.seg.kind = tsqe_pkg::KIND_DIAG;
    end
    a_side_next.seg.same_sign = (dx[tsqe_pkg::DIFF_W-1] == dy[tsqe_pkg::DIFF_W-1]);
    a_side_next.adx = adx_full[tsqe_pkg::MAG_W-1:0];
    a_side_next.ady = ady_full[tsqe_pkg::MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= segment.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side <= a_side_next;
    end
  end

  // squares
  logic                       b_valid;
  tsqe_pkg::sqrt_side_t       b_side;
  logic [tsqe_pkg::SQ_W-1:0]  sq_x;
  logic [tsqe_pkg::SQ_W-1:0]  sq_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_side <= a_side;
      sq_x   <= a_side.adx * a_side.adx;
      sq_y   <= a_side.ady * a_side.ady;
    end
  end

  // radicand, then the square-root chain
  logic                 sq_valid [0:ROOT_W];
  tsqe_pkg::sqrt_side_t sq_side  [0:ROOT_W];
  tsqe_pkg::sqrt_work_t sq_work  [0:ROOT_W];
  tsqe_pkg::sqrt_work_t c_work_next;

  always_comb begin
    c_work_next.rad  = tsqe_pkg::RAD_W'({1'b0, sq_x} + {1'b0, sq_y}) << tsqe_pkg::RAD_SHIFT;
    c_work_next.rem  = '0;
    c_work_next.root = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid[0] <= 1'b0;
    end else if (en) begin
      sq_valid[0] <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side[0] <= b_side;
      sq_work[0] <= c_work_next;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    tsqe_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (sq_valid[k]),
      .side_in   (sq_side[k]),
      .work_in   (sq_work[k]),
      .valid_out (sq_valid[k+1]),
      .side_out  (sq_side[k+1]),
      .work_out  (sq_work[k+1])
    );
  end

  // divider chain for both normal components
  logic                  dv_valid [0:QW];
  tsqe_pkg::seg_t        dv_seg   [0:QW];
  logic [ROOT_W-1:0]     dv_len   [0:QW];
  logic [ROOT_W-1:0]     dv_rc    [0:QW];
  logic [ROOT_W-1:0]     dv_rs    [0:QW];
  logic [QW-1:0]         dv_qc    [0:QW];
  logic [QW-1:0]         dv_qs    [0:QW];

  assign dv_valid[0] = sq_valid[ROOT_W];
  assign dv_seg[0]   = sq_side[ROOT_W].seg;
  assign dv_len[0]   = sq_work[ROOT_W].root;
  assign dv_rc[0]    = ROOT_W'(sq_side[ROOT_W].ady) << tsqe_pkg::DIV_PRESHIFT;
  assign dv_rs[0]    = ROOT_W'(sq_side[ROOT_W].adx) << tsqe_pkg::DIV_PRESHIFT;
  assign dv_qc[0]    = '0;
  assign dv_qs[0]    = '0;

  for (genvar k = 0; k < QW; k++) begin : g_div
    tsqe_div_cell #(.QW(QW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (dv_valid[k]),
      .seg_in    (dv_seg[k]),
      .len_in    (dv_len[k]),
      .rem_c_in  (dv_rc[k]),
      .rem_s_in  (dv_rs[k]),
      .q_c_in    (dv_qc[k]),
      .q_s_in    (dv_qs[k]),
      .valid_out (dv_valid[k+1]),
      .seg_out   (dv_seg[k+1]),
      .len_out   (dv_len[k+1]),
      .rem_c_out (dv_rc[k+1]),
      .rem_s_out (dv_rs[k+1]),
      .q_c_out   (dv_qc[k+1]),
      .q_s_out   (dv_qs[k+1])
    );
  end

  // scale by width
  logic [QW-1:0]             uc;
  logic [QW-1:0]             us;
  logic [PW-1:0]             prod_c;
  logic [PW-1:0]             prod_s;
  logic [tsqe_pkg::LW_W:0]   width_inc;
  logic                      m_valid;
  tsqe_pkg::seg_t            m_seg;
  logic [tsqe_pkg::LW_W-1:0] m_oc;
  logic [tsqe_pkg::LW_W-1:0] m_os;
  logic [tsqe_pkg::LW_W-1:0] m_h;

  always_comb begin
    uc = (dv_qc[QW] > UNIT_ONE) ? UNIT_ONE : dv_qc[QW];
    us = (dv_qs[QW] > UNIT_ONE) ? UNIT_ONE : dv_qs[QW];
    prod_c = PW'(line_width) * PW'(uc) + ROUND_HALF;
    prod_s = PW'(line_width) * PW'(us) + ROUND_HALF;
    width_inc = {1'b0, line_width} + (tsqe_pkg::LW_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= dv_valid[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_seg <= dv_seg[QW];
      m_oc  <= prod_c[NORMAL_ITERATIONS+1 +: tsqe_pkg::LW_W];
      m_os  <= prod_s[NORMAL_ITERATIONS+1 +: tsqe_pkg::LW_W];
      m_h   <= width_inc[tsqe_pkg::LW_W:1];
    end
  end

  // corners with saturation
  logic signed [tsqe_pkg::OFS_W-1:0] h_s;
  logic signed [tsqe_pkg::OFS_W-1:0] oc_s;
  logic signed [tsqe_pkg::OFS_W-1:0] os_s;
  logic signed [tsqe_pkg::OFS_W-1:0] ox0;
  logic signed [tsqe_pkg::OFS_W-1:0] oy0;
  logic signed [tsqe_pkg::OFS_W-1:0] ox1;
  logic signed [tsqe_pkg::OFS_W-1:0] oy1;
  tsqe_pkg::quad_t                   corners;

  always_comb begin
    h_s  = signed'({1'b0, m_h});
    oc_s = signed'({1'b0, m_oc});
    os_s = signed'({1'b0, m_os});
    case (m_seg.kind)
      tsqe_pkg::KIND_VERT: begin
        ox0 = -h_s;
        oy0 = '0;
        ox1 = h_s;
        oy1 = '0;
      end
      tsqe_pkg::KIND_HORZ: begin
        ox0 = '0;
        oy0 = h_s;
        ox1 = '0;
        oy1 = -h_s;
      end
      default: begin
        ox0 = m_seg.same_sign ? -oc_s : oc_s;
        oy0 = os_s;
        ox1 = m_seg.same_sign ? oc_s : -oc_s;
        oy1 = -os_s;
      end
    endcase
    corners.c0x = tsqe_pkg::sat(tsqe_pkg::SUM_W'(m_seg.sx) + tsqe_pkg::SUM_W'(ox0));
    corners.c0y = tsqe_pkg::sat(tsqe_pkg::SUM_W'(m_seg.sy) + tsqe_pkg::SUM_W'(oy0));
    corners.c1x = tsqe_pkg::sat(tsqe_pkg::SUM_W'(m_seg.sx) + tsqe_pkg::SUM_W'(ox1));
    corners.c1y = tsqe_pkg::sat(tsqe_pkg::SUM_W'(m_seg.sy) + tsqe_pkg::SUM_W'(oy1));
    corners.c2x = tsqe_pkg::sat(tsqe_pkg::SUM_W'(m_seg.ex) + tsqe_pkg::SUM_W'(ox0));
    corners.c2y = tsqe_pkg::sat(tsqe_pkg::SUM_W'(m_seg.ey) + tsqe_pkg::SUM_W'(oy0));
    corners.c3x = tsqe_pkg::sat(tsqe_pkg::SUM_W'(m_seg.ex) + tsqe_pkg::SUM_W'(ox1));
    corners.c3y = tsqe_pkg::sat(tsqe_pkg::SUM_W'(m_seg.ey) + tsqe_pkg::SUM_W'(oy1));
  end

  tsqe_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push_valid (m_valid),
    .push_data  (corners),
    .room       (en),
    .quad       (quad)
  );

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the thick segment quad expander.
`default_nettype none

module testbench;

  localparam int NORM_BITS   = 16;
  localparam int LEN_SHIFT   = 14;
  localparam int DRAIN_WAIT  = 60;
  localparam int CYCLE_LIMIT = 300000;
  localparam int BLOCK_SPAN  = 300;

  typedef logic signed [tsqe_pkg::COORD_W-1:0] coord_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [tsqe_pkg::LW_W-1:0] cfg_data;

  tsqe_seg_if  seg_ch();
  tsqe_quad_if quad_ch();

  thick_segment_quad_expand DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .segment  (seg_ch),
    .quad     (quad_ch)
  );

  tsqe_pkg::quad_t           expected_quads[$];
  logic [tsqe_pkg::LW_W-1:0] line_width_model = tsqe_pkg::LINE_WIDTH_RESET;
  int                        mismatches = 0;
  int                        cycles = 0;
  bit                        tx_idle_en = 1'b1;
  bit                        rx_idle_en = 1'b1;
  bit                        rx_blocked = 1'b0;
  string                     corner_names[8] = '{"corner0_x", "corner0_y", "corner1_x",
                                                 "corner1_y", "corner2_x", "corner2_y",
                                                 "corner3_x", "corner3_y"};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned root, probe, rest;
    root  = 0;
    rest  = n;
    probe = 64'd1 << 62;
    while (probe > rest) probe >>= 2;
    while (probe != 0) begin
      if (rest >= root + probe) begin
        rest -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  function automatic longint normal_offset(input longint unsigned mag, input longint unsigned len,
                                           input logic [tsqe_pkg::LW_W-1:0] lw);
    longint unsigned unit_frac;
    unit_frac = (mag << (NORM_BITS + 7)) / len;
    if (unit_frac > (64'd1 << NORM_BITS)) unit_frac = 64'd1 << NORM_BITS;
    return longint'((longint'(lw) * unit_frac + (64'd1 << NORM_BITS)) >> (NORM_BITS + 1));
  endfunction

  function automatic coord_t clamp_coord(input longint v);
    if (v > longint'(tsqe_pkg::COORD_MAX)) return tsqe_pkg::COORD_MAX;
    if (v < longint'(tsqe_pkg::COORD_MIN)) return tsqe_pkg::COORD_MIN;
    return v[tsqe_pkg::COORD_W-1:0];
  endfunction

  function automatic tsqe_pkg::quad_t expand_segment(input coord_t ax, input coord_t ay,
                                                     input coord_t bx, input coord_t by,
                                                     input logic [tsqe_pkg::LW_W-1:0] lw);
    longint          dx, dy, s_x, s_y, e_x, e_y, half, off_c, off_s;
    longint          dx0, dy0, dx1, dy1;
    longint unsigned adx, ady, len;
    logic            swap_ends;
    tsqe_pkg::quad_t q;
    dx = longint'(bx) - longint'(ay - ay + ax);
    dy = longint'(by) - longint'(ay);
    swap_ends = (dx == 0) ? !(ay < by) : !(ax < bx);
    if (swap_ends) begin
      s_x = bx; s_y = by; e_x = ax; e_y = ay;
    end else begin
      s_x = ax; s_y = ay; e_x = bx; e_y = by;
    end
    half = (longint'(lw) + 1) >>> 1;
    if (dx == 0) begin
      dx0 = -half; dy0 = 0; dx1 = half; dy1 = 0;
    end else if (dy == 0) begin
      dx0 = 0; dy0 = half; dx1 = 0; dy1 = -half;
    end else begin
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      len = floor_sqrt((adx * adx + ady * ady) << LEN_SHIFT);
      if (len == 0) len = 1;
      off_c = normal_offset(ady, len, lw);
      off_s = normal_offset(adx, len, lw);
      if ((dx > 0) == (dy > 0)) begin
        dx0 = -off_c; dy0 = off_s; dx1 = off_c; dy1 = -off_s;
      end else begin
        dx0 = off_c; dy0 = off_s; dx1 = -off_c; dy1 = -off_s;
      end
    end
    q.c0x = clamp_coord(s_x + dx0);
    q.c0y = clamp_coord(s_y + dy0);
    q.c1x = clamp_coord(s_x + dx1);
    q.c1y = clamp_coord(s_y + dy1);
    q.c2x = clamp_coord(e_x + dx0);
    q.c2y = clamp_coord(e_y + dy0);
    q.c3x = clamp_coord(e_x + dx1);
    q.c3y = clamp_coord(e_y + dy1);
    return q;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH: %s", what);
    mismatches++;
  endtask

  initial begin : quad_checker
    tsqe_pkg::quad_t got, want;
    int              hold;
    int              quads_seen;
    hold       = 0;
    quads_seen = 0;
    quad_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && quad_ch.valid && quad_ch.ready) begin
        got = '{c0x: quad_ch.corner0_x, c0y: quad_ch.corner0_y,
                c1x: quad_ch.corner1_x, c1y: quad_ch.corner1_y,
                c2x: quad_ch.corner2_x, c2y: quad_ch.corner2_y,
                c3x: quad_ch.corner3_x, c3y: quad_ch.corner3_y};
        if (expected_quads.size() == 0) begin
          report_mismatch($sformatf("quad %0d arrived with none outstanding", quads_seen));
        end else begin
          want = expected_quads.pop_front();
          for (int i = 0; i < 8; i++) begin
            if (got[(7-i)*tsqe_pkg::COORD_W +: tsqe_pkg::COORD_W] !==
                want[(7-i)*tsqe_pkg::COORD_W +: tsqe_pkg::COORD_W])
              report_mismatch($sformatf("quad %0d %s got %0d expected %0d", quads_seen,
                corner_names[i],
                $signed(got[(7-i)*tsqe_pkg::COORD_W +: tsqe_pkg::COORD_W]),
                $signed(want[(7-i)*tsqe_pkg::COORD_W +: tsqe_pkg::COORD_W])));
          end
        end
        quads_seen++;
        hold = rx_idle_en ? $urandom_range(0, 9) : 0;
      end
      if (rst || rx_blocked) begin
        quad_ch.ready <= 1'b0;
      end else if (hold > 0) begin
        quad_ch.ready <= 1'b0;
        hold--;
      end else begin
        quad_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_segment(input coord_t ax, input coord_t ay,
                              input coord_t bx, input coord_t by);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      seg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    seg_ch.valid   <= 1'b1;
    seg_ch.start_x <= ax;
    seg_ch.start_y <= ay;
    seg_ch.end_x   <= bx;
    seg_ch.end_y   <= by;
    do @(posedge clk); while (!seg_ch.ready);
    expected_quads.push_back(expand_segment(ax, ay, bx, by, line_width_model));
  endtask

  task automatic drain_pipeline();
    seg_ch.valid <= 1'b0;
    while (expected_quads.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_line_width(input logic [tsqe_pkg::LW_W-1:0] w);
    drain_pipeline();
    cfg_we   <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    line_width_model = w;
  endtask

  function automatic coord_t pick_extreme();
    case ($urandom_range(0, 5))
      0:       return tsqe_pkg::COORD_MIN;
      1:       return tsqe_pkg::COORD_MAX;
      2:       return tsqe_pkg::COORD_MIN + coord_t'($urandom_range(0, 1023));
      3:       return tsqe_pkg::COORD_MAX - coord_t'($urandom_range(0, 1023));
      4:       return coord_t'(0);
      default: return coord_t'(-1);
    endcase
  endfunction

  task automatic pick_segment(output coord_t ax, output coord_t ay,
                              output coord_t bx, output coord_t by);
    int delta_x, delta_y;
    ax = coord_t'($urandom);
    ay = coord_t'($urandom);
    bx = coord_t'($urandom);
    by = coord_t'($urandom);
    delta_x = $urandom_range(0, 4095) - 2048;
    delta_y = $urandom_range(0, 4095) - 2048;
    case ($urandom_range(0, 9))
      1: bx = ax;
      2: by = ay;
      3: begin
        bx = ax;
        by = ay;
      end
      4: begin
        ax = pick_extreme();
        ay = pick_extreme();
        bx = pick_extreme();
        by = pick_extreme();
      end
      5, 6: begin
        bx = ax + coord_t'(delta_x);
        by = ay + coord_t'(delta_y);
      end
      7: begin
        bx = ax + coord_t'(delta_x);
        by = $urandom_range(0, 1) ? ay + coord_t'(delta_x) : ay - coord_t'(delta_x);
      end
      8: begin
        if ($urandom_range(0, 1)) bx = ax + ($urandom_range(0, 1) ? coord_t'(1) : coord_t'(-1));
        else by = ay + ($urandom_range(0, 1) ? coord_t'(1) : coord_t'(-1));
      end
      default: ;
    endcase
  endtask

  task automatic test_directed_shapes();
    send_segment(0, 0, 0, 0);
    send_segment(100, -500, 100, 700);
    send_segment(100, 700, 100, -500);
    send_segment(-300, 50, 900, 50);
    send_segment(900, 50, -300, 50);
    send_segment(0, 0, 256, 512);
    send_segment(256, 512, 0, 0);
    send_segment(0, 0, 512, -256);
    send_segment(512, -256, 0, 0);
    send_segment(tsqe_pkg::COORD_MIN, tsqe_pkg::COORD_MIN,
                 tsqe_pkg::COORD_MAX, tsqe_pkg::COORD_MAX);
    send_segment(tsqe_pkg::COORD_MAX, 0, tsqe_pkg::COORD_MAX, 100);
    send_segment(tsqe_pkg::COORD_MIN, tsqe_pkg::COORD_MIN,
                 tsqe_pkg::COORD_MAX, tsqe_pkg::COORD_MIN);
  endtask

  task automatic test_random_segments(input int count);
    coord_t ax, ay, bx, by;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en <= ($urandom_range(0, 3) != 0);
      end
      pick_segment(ax, ay, bx, by);
      send_segment(ax, ay, bx, by);
    end
  endtask

  task automatic test_width_sweep();
    test_random_segments(180);
    set_line_width(16'd0);
    test_random_segments(180);
    set_line_width(16'hFFFF);
    test_random_segments(180);
    set_line_width(16'd1);
    test_random_segments(180);
    set_line_width(16'($urandom));
    test_random_segments(180);
    set_line_width(16'($urandom));
    test_random_segments(180);
  endtask

  task automatic test_output_backpressure();
    coord_t ax, ay, bx, by;
    drain_pipeline();
    fork
      begin
        rx_blocked <= 1'b1;
        repeat (BLOCK_SPAN) @(posedge clk);
        rx_blocked <= 1'b0;
      end
    join_none
    tx_idle_en = 1'b0;
    for (int i = 0; i < 150; i++) begin
      pick_segment(ax, ay, bx, by);
      send_segment(ax, ay, bx, by);
    end
    tx_idle_en = 1'b1;
  endtask

  initial begin
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_data       <= '0;
    seg_ch.valid   <= 1'b0;
    seg_ch.start_x <= '0;
    seg_ch.start_y <= '0;
    seg_ch.end_x   <= '0;
    seg_ch.end_y   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_shapes();
    set_line_width(16'hFFFF);
    test_directed_shapes();
    set_line_width(tsqe_pkg::LINE_WIDTH_RESET);
    test_width_sweep();
    test_output_backpressure();

    drain_pipeline();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_quads.size() != 0)
      report_mismatch($sformatf("%0d quads never arrived", expected_quads.size()));
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[thick_segment_quad_expand.f]
design/tsqe_pkg.sv
design/tsqe_if.sv
design/tsqe_sqrt_cell.sv
design/tsqe_div_cell.sv
design/tsqe_skid.sv
design/thick_segment_quad_expand.sv
tb/sv/testbench.sv
